// ===== src/next_alarm_delay_assert.svh =====
// Assertion macros for the next alarm delay block.
// NAD_ASSERT checks a property at each rising clock edge outside reset.
// NAD_ASSERT_ALWAYS checks a property at each rising clock edge, reset included.
`ifndef NEXT_ALARM_DELAY_ASSERT_SVH
`define NEXT_ALARM_DELAY_ASSERT_SVH
`ifndef ASSERT_OFF
`define NAD_ASSERT(label, clock, rst_n, prop) \
	label: assert property (@(posedge clock) disable iff (!rst_n) prop) \
		else $error("next_alarm_delay: assertion failed");
`define NAD_ASSERT_ALWAYS(label, clock, prop) \
	label: assert property (@(posedge clock) prop) \
		else $error("next_alarm_delay: assertion failed");
`else
`define NAD_ASSERT(label, clock, rst_n, prop)
`define NAD_ASSERT_ALWAYS(label, clock, prop)
`endif
`endif

// ===== src/nad_pkg.sv =====
`default_nettype none

package nad_pkg;

	// Time constants.
	localparam int SEC_PER_HOUR  = 3600;
	localparam int SEC_PER_MIN   = 60;
	localparam int SEC_PER_DAY   = 86400;
	localparam int DAYS_PER_WEEK = 7;
	localparam int SEC_PER_WEEK  = SEC_PER_DAY * DAYS_PER_WEEK;

	// Seconds into a day fit in 17 bits, a weekly delay in 20 bits.
	localparam int TOD_W   = 17;
	localparam int DELAY_W = 20;

	// Saturation limits of the time fields.
	localparam logic [2:0] DAY_MAX  = 3'd6;
	localparam logic [4:0] HOUR_MAX = 5'd23;
	localparam logic [5:0] MIN_MAX  = 6'd59;

	typedef enum logic [1:0] {
		REG_MODE     = 2'd0,
		REG_INTERVAL = 2'd1,
		REG_COUNT    = 2'd2
	} reg_idx_t;

	typedef enum logic [1:0] {
		MODE_ONESHOT  = 2'd0,
		MODE_INTERVAL = 2'd1,
		MODE_DAILY    = 2'd2,
		MODE_WEEKLY   = 2'd3
	} mode_t;

	typedef enum logic {
		OP_WRITE = 1'b0,
		OP_QUERY = 1'b1
	} op_t;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_EMPTY    = 2'd1,
		ST_NO_RECUR = 2'd2
	} status_t;

	// One stored alarm: weekday, hour and minute.
	typedef struct packed {
		logic [2:0] day;
		logic [4:0] hour;
		logic [5:0] minute;
	} entry_t;

	function automatic logic [2:0] sat_day(input logic [2:0] v);
		return (v > DAY_MAX) ? DAY_MAX : v;
	endfunction

	function automatic logic [4:0] sat_hour(input logic [4:0] v);
		return (v > HOUR_MAX) ? HOUR_MAX : v;
	endfunction

	function automatic logic [5:0] sat_min(input logic [5:0] v);
		return (v > MIN_MAX) ? MIN_MAX : v;
	endfunction

	// Seconds since midnight for an hour and minute.
	function automatic logic [TOD_W-1:0] tod(input logic [4:0] h, input logic [5:0] m);
		return TOD_W'(h) * TOD_W'(SEC_PER_HOUR) + TOD_W'(m) * TOD_W'(SEC_PER_MIN);
	endfunction

endpackage

`default_nettype wire

// ===== src/next_alarm_delay.sv =====
// Next alarm delay: seconds until the nearest stored alarm.
//
// Input stream (s_axis): tuser selects the operation, write or query; tdata carries the
// table slot and alarm time for a write, or the current weekday and time for a query.
// Output stream (m_axis): one beat per input beat, the delay in tdata and the status
// in tuser. The config channel writes the mode, interval and entry count registers;
// it is always ready. The user must write it only while the block has no work in flight;
// the block itself does not enforce this.
// A write, or a query that needs no table scan (one-shot, interval or empty table),
// goes from the sequencer straight to the output register, and the next beat can be
// taken once it has moved there. A daily or weekly query reads the alarm table one
// entry per cycle through a three-stage read, delay and minimum pipeline, over n
// entries with n the entry count clamped to the table depth; the minimum then moves
// to the output register, and the next beat is taken once it has moved there.
// s_axis_tready is low from acceptance until the result moves to the output register,
// so a new beat can be taken while a result waits; a longer receiver stall holds the
// next result in the sequencer until the output register empties.
//
// Reset clears the config registers, the sequencer and the output register. The alarm
// table is not cleared; a slot must be written before a query scans it.
`default_nettype none

module next_alarm_delay #(
	parameter int MAX_ENTRIES = 8
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// Configuration write channel.
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [31:0] cfg_data,
	// Input stream.
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	// tdata from bit 0: entry_index[3], entry_day[3], entry_hour[5], entry_minute[6],
	// now_weekday[3], now_hour[5], now_minute[6], now_second[6], zero pad[3]
	input  wire logic [39:0] s_axis_tdata,
	// tuser: operation[1]
	input  wire logic [0:0]  s_axis_tuser,
	// Output stream.
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	// tdata: delay_seconds[32]
	output logic [31:0]      m_axis_tdata,
	// tuser: status[2]
	output logic [1:0]       m_axis_tuser
);

	localparam int AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
	localparam int CW = $clog2(MAX_ENTRIES + 1);
	localparam int DW = nad_pkg::DELAY_W;
	localparam int TW = nad_pkg::TOD_W;

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_DONE
	} state_t;

	// Input field unpacking.
	logic [2:0] in_index;
	logic [2:0] in_day;
	logic [4:0] in_hour;
	logic [5:0] in_minute;
	logic [2:0] in_wday;
	logic [4:0] in_now_hour;
	logic [5:0] in_now_minute;
	logic [5:0] in_now_second;
	logic       in_acc;

	assign in_index      = s_axis_tdata[2:0];
	assign in_day        = s_axis_tdata[5:3];
	assign in_hour       = s_axis_tdata[10:6];
	assign in_minute     = s_axis_tdata[16:11];
	assign in_wday       = s_axis_tdata[19:17];
	assign in_now_hour   = s_axis_tdata[24:20];
	assign in_now_minute = s_axis_tdata[30:25];
	assign in_now_second = s_axis_tdata[36:31];

	state_t state_q;
	assign s_axis_tready = (state_q == S_IDLE);
	assign in_acc        = s_axis_tvalid && s_axis_tready;

	// Configuration registers.
	nad_pkg::mode_t mode_q;
	logic [31:0]    interval_q;
	logic [3:0]     count_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q     <= nad_pkg::MODE_ONESHOT;
			interval_q <= '0;
			count_q    <= '0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				nad_pkg::REG_MODE:     mode_q     <= nad_pkg::mode_t'(cfg_data[1:0]);
				nad_pkg::REG_INTERVAL: interval_q <= cfg_data;
				nad_pkg::REG_COUNT:    count_q    <= cfg_data[3:0];
				default: ;
			endcase
		end
	end

	// Number of entries to scan, clamped to the table depth.
	logic [CW-1:0] n_d;
	assign n_d = (int'(count_q) > MAX_ENTRIES) ? CW'(MAX_ENTRIES) : CW'(count_q);

	// Alarm table, written by write items and read one slot per cycle by the scan.
	nad_pkg::entry_t alarm_mem [MAX_ENTRIES];
	nad_pkg::entry_t wr_entry;
	nad_pkg::entry_t rd_s1;
	logic            wr_en;
	logic [CW-1:0]   addr_q;

	assign wr_entry.day    = nad_pkg::sat_day(in_day);
	assign wr_entry.hour   = nad_pkg::sat_hour(in_hour);
	assign wr_entry.minute = nad_pkg::sat_min(in_minute);
	assign wr_en = in_acc && (s_axis_tuser[0] == nad_pkg::OP_WRITE)
		&& (int'(in_index) < MAX_ENTRIES);

	always_ff @(posedge clk) begin
		if (wr_en) begin
			alarm_mem[AW'(in_index)] <= wr_entry;
		end
		rd_s1 <= alarm_mem[addr_q[AW-1:0]];
	end

	// Query time, captured at acceptance.
	logic [2:0]    wday_q;
	logic [TW-1:0] cur_q;

	// Delay unit: one entry per cycle, shared by the daily and weekly rules.
	logic [TW-1:0] tgt;
	logic          later_today;
	logic [3:0]    day_diff;
	logic [2:0]    day_wrap;
	logic [2:0]    days_ahead;
	logic [DW-1:0] d_calc;

	always_comb begin
		tgt         = nad_pkg::tod(rd_s1.hour, rd_s1.minute);
		later_today = (tgt > cur_q);
		day_diff    = 4'(rd_s1.day) + 4'(nad_pkg::DAYS_PER_WEEK) - 4'(wday_q);
		day_wrap    = (day_diff >= 4'(nad_pkg::DAYS_PER_WEEK))
			? 3'(day_diff - 4'(nad_pkg::DAYS_PER_WEEK)) : 3'(day_diff);
		if (mode_q == nad_pkg::MODE_DAILY) begin
			days_ahead = later_today ? 3'd0 : 3'd1;
		end else begin
			days_ahead = ((day_wrap == 3'd0) && !later_today)
				? 3'(nad_pkg::DAYS_PER_WEEK) : day_wrap;
		end
		d_calc = DW'(days_ahead) * DW'(nad_pkg::SEC_PER_DAY) + DW'(tgt) - DW'(cur_q);
	end

	// Scan pipeline data: delay per entry, then running minimum.
	logic          v_s1;
	logic          v_s2;
	logic [DW-1:0] d_s2;
	logic [DW-1:0] best_q;

	always_ff @(posedge clk) begin
		if (in_acc) begin
			wday_q <= nad_pkg::sat_day(in_wday);
			cur_q  <= nad_pkg::tod(nad_pkg::sat_hour(in_now_hour), nad_pkg::sat_min(in_now_minute))
				+ TW'(nad_pkg::sat_min(in_now_second));
		end
		d_s2 <= d_calc;
		if (in_acc) begin
			best_q <= '1;
		end else if (v_s2 && (d_s2 < best_q)) begin
			best_q <= d_s2;
		end
	end

	// Sequencer and output register.
	logic [CW-1:0]    n_q;
	logic [31:0]      res_delay_q;
	nad_pkg::status_t res_status_q;
	logic             out_valid_q;
	logic [31:0]      out_delay_q;
	nad_pkg::status_t out_status_q;
	logic             out_load;

	assign out_load = (state_q == S_DONE) && (!out_valid_q || m_axis_tready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			v_s1         <= 1'b0;
			v_s2         <= 1'b0;
			addr_q       <= '0;
			n_q          <= '0;
			res_delay_q  <= '0;
			res_status_q <= nad_pkg::ST_OK;
			out_valid_q  <= 1'b0;
			out_delay_q  <= '0;
			out_status_q <= nad_pkg::ST_OK;
		end else begin
			v_s1 <= (state_q == S_SCAN) && (addr_q != n_q);
			v_s2 <= v_s1;
			if (out_load) begin
				out_valid_q  <= 1'b1;
				out_delay_q  <= res_delay_q;
				out_status_q <= res_status_q;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						addr_q <= '0;
						n_q    <= n_d;
						if (s_axis_tuser[0] == nad_pkg::OP_WRITE) begin
							res_delay_q  <= '0;
							res_status_q <= nad_pkg::ST_OK;
							state_q      <= S_DONE;
						end else begin
							unique case (mode_q)
								nad_pkg::MODE_ONESHOT: begin
									res_delay_q  <= '0;
									res_status_q <= nad_pkg::ST_NO_RECUR;
									state_q      <= S_DONE;
								end
								nad_pkg::MODE_INTERVAL: begin
									res_delay_q  <= interval_q;
									res_status_q <= nad_pkg::ST_OK;
									state_q      <= S_DONE;
								end
								default: begin
									res_delay_q <= '0;
									if (n_d == '0) begin
										res_status_q <= nad_pkg::ST_EMPTY;
										state_q      <= S_DONE;
									end else begin
										res_status_q <= nad_pkg::ST_OK;
										state_q      <= S_SCAN;
									end
								end
							endcase
						end
					end
				end
				S_SCAN: begin
					if (addr_q != n_q) begin
						addr_q <= CW'(addr_q + 1'b1);
					end else if (!v_s1 && !v_s2) begin
						res_delay_q <= 32'(best_q);
						state_q     <= S_DONE;
					end
				end
				S_DONE: begin
					if (out_load) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_delay_q;
	assign m_axis_tuser  = out_status_q;

	// Checks.
	`include "next_alarm_delay_assert.svh"

	`NAD_ASSERT(a_idle_no_scan, clk, arst_n, s_axis_tready |-> (!v_s1 && !v_s2))
	`NAD_ASSERT(a_addr_bound, clk, arst_n, (state_q == S_SCAN) |-> (addr_q <= n_q))
	`NAD_ASSERT(a_error_zero, clk, arst_n,
		(m_axis_tvalid && (m_axis_tuser != nad_pkg::ST_OK)) |-> (m_axis_tdata == 32'd0))
	`NAD_ASSERT(a_week_bound, clk, arst_n,
		(m_axis_tvalid && ((mode_q == nad_pkg::MODE_DAILY) || (mode_q == nad_pkg::MODE_WEEKLY)))
		|-> (m_axis_tdata <= 32'(nad_pkg::SEC_PER_WEEK)))

endmodule

`default_nettype wire
